@@ rtl/core/three_axis_pid_controller_unit_macros.svh @@
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef THREE_AXIS_PID_CONTROLLER_UNIT_MACROS_SVH
`define THREE_AXIS_PID_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define TAPID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAPID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tapid_pkg.sv @@
package tapid_pkg;

  localparam int AXES_DEF   = 3;
  localparam int FLD_W      = 16;
  localparam int REG_W      = 48;
  localparam int NUM_LANES  = 3;
  localparam int LANE_IDX_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int INT_W      = 25;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int SUM_W      = 34;
  localparam int OUT_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAINS  = 2'd0,
    REG_INTEG_GAINS = 2'd1,
    REG_DERIV_GAINS = 2'd2,
    REG_INT_LIMITS  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_PROP,
    ST_DERIV,
    ST_INTEG,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_ERR_DT,
    MUL_ERR_KP,
    MUL_RATE_KD,
    MUL_INT_KI
  } mul_op_t;

  typedef struct packed {
    logic    mul_en;
    mul_op_t mul_op;
    logic    int_wr;
    logic    acc_init;
    logic    acc_add;
    logic    res_wr;
    logic    out_load;
  } ctrl_t;

  // 16-bit lane of a packed register; lanes past the register read as zero
  function automatic logic [FLD_W-1:0] reg_lane(input logic [REG_W-1:0] r,
                                                input logic [LANE_IDX_W-1:0] a);
    if (a < LANE_IDX_W'(NUM_LANES)) begin
      reg_lane = r[a*FLD_W +: FLD_W];
    end else begin
      reg_lane = '0;
    end
  endfunction

endpackage

@@ rtl/core/tapid_mul.sv @@
module tapid_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tapid_pkg::MUL_A_W-1:0] a,
  input  logic signed [tapid_pkg::MUL_B_W-1:0] b,
  output logic signed [tapid_pkg::PROD_W-1:0]  p
);
  import tapid_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

@@ rtl/core/tapid_seq.sv @@
module tapid_seq #(
  parameter int AXES = tapid_pkg::AXES_DEF,
  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_free,
  output logic              ready,
  output logic [AXIS_W-1:0] axis,
  output tapid_pkg::ctrl_t  ctrl
);
  import tapid_pkg::*;

  state_t state, state_next;
  logic   last_axis;

  assign last_axis = (axis == AXIS_W'(AXES - 1));
  assign ready     = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        axis <= '0;
      end else if (state == ST_FINISH && !last_axis) begin
        axis <= axis + AXIS_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire) state_next = ST_INC;
      ST_INC:    state_next = ST_PROP;
      ST_PROP:   state_next = ST_DERIV;
      ST_DERIV:  state_next = ST_INTEG;
      ST_INTEG:  state_next = ST_FINISH;
      ST_FINISH: state_next = last_axis ? ST_DONE : ST_INC;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      ST_INC: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MUL_ERR_DT;
      end
      ST_PROP: begin
        ctrl.mul_en   = 1'b1;
        ctrl.mul_op   = MUL_ERR_KP;
        ctrl.int_wr   = 1'b1;
        ctrl.acc_init = 1'b1;
      end
      ST_DERIV: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_op  = MUL_RATE_KD;
        ctrl.acc_add = 1'b1;
      end
      ST_INTEG: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_op  = MUL_INT_KI;
        ctrl.acc_add = 1'b1;
      end
      ST_FINISH: ctrl.res_wr   = 1'b1;
      ST_DONE:   ctrl.out_load = out_free;
      default:   ctrl = '0;
    endcase
  end

endmodule

@@ rtl/core/three_axis_pid_controller_unit.sv @@
// Channel  Dir  Contents
// s_*      in   tdata: ff x..z, err x..z, rate x..z, time_step; tuser: clear_integral
// m_*      out  tdata: drive x..z; tuser: output_saturated
// cfg_*    in   write enable, register index, 48-bit data
//
// An item is worked on one axis at a time from transfer to m_tvalid;
// each axis runs four products through the single 25x17 multiplier.
// s_tready is high only while the sequencer is idle, so a new item is taken only after
// the previous result has been loaded into the output register.
// A finished result waits in the output register; the next item is taken meanwhile.
// rst clears integrals, gains, limits and the sequencer.
`include "three_axis_pid_controller_unit_macros.svh"

module three_axis_pid_controller_unit #(
  parameter int AXES = tapid_pkg::AXES_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // ff_x..ff_z, error_x..error_z, error_rate_x..error_rate_z, time_step
  input  logic [(3*AXES+1)*tapid_pkg::FLD_W-1:0]   s_tdata,
  // clear_integral
  input  logic                                      s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // drive_x..drive_z
  output logic [AXES*tapid_pkg::OUT_W-1:0]          m_tdata,
  // output_saturated
  output logic                                      m_tuser,
  input  logic                                      cfg_we,
  input  logic [tapid_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [tapid_pkg::REG_W-1:0]               cfg_data
);
  import tapid_pkg::*;

  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int IN_W   = (3*AXES+1)*FLD_W;

  logic [REG_W-1:0] prop_gains, integ_gains, deriv_gains, integral_limits;

  logic [IN_W-1:0] in_data;
  logic            in_clear;
  logic            in_fire;
  logic            out_free;

  logic [AXIS_W-1:0] axis;
  ctrl_t             ctrl;

  logic signed [INT_W-1:0] integral_sum [AXES];
  logic signed [OUT_W-1:0] res [AXES];
  logic                    sat_flag;
  logic signed [SUM_W-1:0] sum_acc;

  logic signed [FLD_W-1:0] ff_sel, err_sel, rate_sel;
  logic        [FLD_W-1:0] dt, lim;
  logic signed [FLD_W-1:0] kp, ki, kd;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic signed [INT_W:0]   int_base, int_raw, lim_pos, lim_neg, int_clamped;
  logic signed [SUM_W-1:0] sum_final;
  logic signed [OUT_W-1:0] drive_sat;
  logic                    drive_ovf;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  tapid_seq #(.AXES(AXES)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ready    (s_tready),
    .axis     (axis),
    .ctrl     (ctrl)
  );

  tapid_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gains      <= '0;
      integ_gains     <= '0;
      deriv_gains     <= '0;
      integral_limits <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAINS:  prop_gains      <= cfg_data;
        REG_INTEG_GAINS: integ_gains     <= cfg_data;
        REG_DERIV_GAINS: deriv_gains     <= cfg_data;
        REG_INT_LIMITS:  integral_limits <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data  <= s_tdata;
      in_clear <= s_tuser;
    end
  end

  assign ff_sel   = signed'(in_data[axis*FLD_W +: FLD_W]);
  assign err_sel  = signed'(in_data[(AXES + axis)*FLD_W +: FLD_W]);
  assign rate_sel = signed'(in_data[(2*AXES + axis)*FLD_W +: FLD_W]);
  assign dt       = in_data[3*AXES*FLD_W +: FLD_W];

  assign kp  = signed'(reg_lane(prop_gains, LANE_IDX_W'(axis)));
  assign ki  = signed'(reg_lane(integ_gains, LANE_IDX_W'(axis)));
  assign kd  = signed'(reg_lane(deriv_gains, LANE_IDX_W'(axis)));
  assign lim = reg_lane(integral_limits, LANE_IDX_W'(axis));

  always_comb begin
    case (ctrl.mul_op)
      MUL_ERR_DT: begin
        mul_a = MUL_A_W'(err_sel);
        mul_b = signed'({1'b0, dt});
      end
      MUL_ERR_KP: begin
        mul_a = MUL_A_W'(err_sel);
        mul_b = MUL_B_W'(kp);
      end
      MUL_RATE_KD: begin
        mul_a = MUL_A_W'(rate_sel);
        mul_b = MUL_B_W'(kd);
      end
      MUL_INT_KI: begin
        mul_a = MUL_A_W'(integral_sum[axis]);
        mul_b = MUL_B_W'(ki);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // integral update: floor(err*dt/256) added, then clamped to +/- lim*256
  assign int_base = in_clear ? '0 : (INT_W+1)'(integral_sum[axis]);
  assign int_raw  = int_base + (INT_W+1)'(signed'(prod[INT_W+7:8]));
  assign lim_pos  = signed'({2'b00, lim, 8'h00});
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (int_raw > lim_pos) begin
      int_clamped = lim_pos;
    end else if (int_raw < lim_neg) begin
      int_clamped = lim_neg;
    end else begin
      int_clamped = int_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        integral_sum[i] <= '0;
      end
    end else if (ctrl.int_wr) begin
      integral_sum[axis] <= INT_W'(int_clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_init) begin
      sum_acc <= SUM_W'(ff_sel) <<< 8;
    end else if (ctrl.acc_add) begin
      sum_acc <= sum_acc + prod[SUM_W-1:0];
    end
  end

  // Ki term drops 8 bits (floor)
  assign sum_final = sum_acc + prod[SUM_W+7:8];

  always_comb begin
    drive_ovf = 1'b1;
    if (sum_final > SUM_W'(signed'(32'sh7FFF_FFFF))) begin
      drive_sat = 32'sh7FFF_FFFF;
    end else if (sum_final < SUM_W'(signed'(32'sh8000_0000))) begin
      drive_sat = 32'sh8000_0000;
    end else begin
      drive_sat = OUT_W'(sum_final);
      drive_ovf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_wr) begin
      res[axis] <= drive_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sat_flag <= 1'b0;
    end else if (ctrl.res_wr && drive_ovf) begin
      sat_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      for (int i = 0; i < AXES; i++) begin
        m_tdata[i*OUT_W +: OUT_W] <= res[i];
      end
      m_tuser <= sat_flag;
    end
  end

  `TAPID_ASSERT_NXT(a_busy_after_take, in_fire, !s_tready, "ready while item in flight")
  `TAPID_ASSERT_IMP(a_load_when_free, ctrl.out_load, out_free, "result overwritten")
  `TAPID_ASSERT_IMP(a_valid_from_load, $rose(m_tvalid), $past(ctrl.out_load),
                    "result without load")

endmodule
